/* design/tpe_pkg.sv */
`default_nettype none

package tpe_pkg;

  // field widths of the command and response channels
  localparam int unsigned CmdW    = 3;
  localparam int unsigned HandleW = 5;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned KindW   = 2;

  // command codes
  localparam logic [CmdW-1:0] CMD_TICK    = 3'd0;
  localparam logic [CmdW-1:0] CMD_ALLOC   = 3'd1;
  localparam logic [CmdW-1:0] CMD_KILL    = 3'd2;
  localparam logic [CmdW-1:0] CMD_RESTART = 3'd3;
  localparam logic [CmdW-1:0] CMD_POLL    = 3'd4;

  // response kinds
  localparam logic [KindW-1:0] KIND_ACK    = 2'd0;
  localparam logic [KindW-1:0] KIND_ALLOC  = 2'd1;
  localparam logic [KindW-1:0] KIND_EXPIRY = 2'd2;

  // period limit and saturation value of the elapsed count
  localparam logic [PeriodW-1:0] PERIOD_MAX = 16'd60000;
  localparam logic [PeriodW-1:0] COUNT_SAT  = 16'd60001;

  // one stored slot word
  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] elapsed;
  } slot_word_t;

  // results of the shared slot unit
  typedef struct packed {
    logic [PeriodW-1:0] elapsed_inc;
    logic               expired;
    logic               period_ok;
  } alu_res_t;

endpackage

`default_nettype wire

/* design/tpe_if.sv */
`default_nettype none

// command channel
interface tpe_cmd_if import tpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    command;
  logic [HandleW-1:0] handle;
  logic [PeriodW-1:0] elapse;
  logic               has_action;

  modport source (output valid, command, handle, elapse, has_action, input ready);
  modport sink   (input valid, command, handle, elapse, has_action, output ready);
endinterface

// response channel
interface tpe_rsp_if import tpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [HandleW-1:0] timer_id;
  logic               last;

  modport source (output valid, kind, timer_id, last, input ready);
  modport sink   (input valid, kind, timer_id, last, output ready);
endinterface

`default_nettype wire

/* design/tpe_slot_ram.sv */
`default_nettype none

module tpe_slot_ram import tpe_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire slot_word_t       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output slot_word_t            rdata_o
);

  slot_word_t mem_q [Depth];
  slot_word_t rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/tpe_slot_alu.sv */
`default_nettype none

module tpe_slot_alu import tpe_pkg::*; (
  input  wire slot_word_t         slot_i,
  input  wire logic [PeriodW-1:0] elapse_i,
  output alu_res_t                res_o
);

  logic [PeriodW:0] inc;

  // saturating increment, expiry compare and period range check
  always_comb begin
    inc = {1'b0, slot_i.elapsed} + {{PeriodW{1'b0}}, 1'b1};
    res_o.elapsed_inc = (inc > {1'b0, PERIOD_MAX}) ? COUNT_SAT : inc[PeriodW-1:0];
    res_o.expired     = (slot_i.elapsed >= slot_i.period);
    res_o.period_ok   = (elapse_i <= PERIOD_MAX);
  end

endmodule

`default_nettype wire

/* design/tpe_seq.sv */
`default_nettype none

module tpe_seq import tpe_pkg::*; #(
  parameter int unsigned PoolDepth = 16,
  parameter int unsigned IdxW      = 4,
  parameter int unsigned CntW      = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  tpe_cmd_if.sink                 cmd_i,
  tpe_rsp_if.source               rsp_o,
  output logic                    ram_we_o,
  output logic [IdxW-1:0]         ram_waddr_o,
  output slot_word_t              ram_wdata_o,
  output logic                    ram_re_o,
  output logic [IdxW-1:0]         ram_raddr_o,
  input  wire slot_word_t         ram_rdata_i,
  output logic [PeriodW-1:0]      alu_elapse_o,
  input  wire alu_res_t           alu_res_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;
  localparam logic [1:0] S_ACK   = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CmdW-1:0]      op_q, op_d;
  logic [PeriodW-1:0]   elapse_q, elapse_d;
  logic                 action_q, action_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic                 pv_q, pv_d;
  logic [IdxW-1:0]      pidx_q, pidx_d;
  logic [PoolDepth-1:0] busy_q, busy_d;
  logic [PoolDepth-1:0] act_q, act_d;

  logic                 out_valid_q, out_valid_d;
  logic [KindW-1:0]     out_kind_q, out_kind_d;
  logic [HandleW-1:0]   out_id_q, out_id_d;
  logic                 out_last_q, out_last_d;

  logic                 out_free;
  logic [7:0]           hsub;
  logic                 handle_ok;
  logic [IdxW-1:0]      hslot;
  logic [IdxW-1:0]      islot;
  logic [7:0]           pid8;
  logic [7:0]           aid8;
  logic                 walk_done;
  logic                 proc_busy;
  logic                 proc_exp;
  logic                 ev;

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign hsub      = 8'(cmd_i.handle) - 8'd1;
  assign handle_ok = (cmd_i.handle != '0) && (8'(cmd_i.handle) <= 8'(PoolDepth));
  assign hslot     = hsub[IdxW-1:0];
  assign islot     = idx_q[IdxW-1:0];
  assign pid8      = 8'(pidx_q) + 8'd1;
  assign aid8      = 8'(idx_q) + 8'd1;
  assign walk_done = (idx_q == CntW'(PoolDepth));
  assign proc_busy = busy_q[pidx_q];
  assign proc_exp  = proc_busy && alu_res_i.expired;
  assign ev        = (op_q == CMD_POLL) && pv_q && proc_exp && act_q[pidx_q];

  assign cmd_i.ready  = (state_q == S_IDLE);
  assign alu_elapse_o = (state_q == S_IDLE) ? cmd_i.elapse : elapse_q;

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.kind     = out_kind_q;
  assign rsp_o.timer_id = out_id_q;
  assign rsp_o.last     = out_last_q;

  // command sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    elapse_d    = elapse_q;
    action_d    = action_q;
    idx_d       = idx_q;
    pv_d        = pv_q;
    pidx_d      = pidx_q;
    busy_d      = busy_q;
    act_d       = act_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pidx_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = islot;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          op_d     = cmd_i.command;
          elapse_d = cmd_i.elapse;
          action_d = cmd_i.has_action;
          idx_d    = '0;
          pv_d     = 1'b0;
          case (cmd_i.command) inside
            CMD_TICK, CMD_POLL: begin
              state_d = S_WALK;
            end
            CMD_ALLOC: begin
              state_d = S_ALLOC;
            end
            CMD_KILL: begin
              if (handle_ok) begin
                busy_d[hslot] = 1'b0;
                act_d[hslot]  = 1'b0;
              end
              state_d = S_ACK;
            end
            CMD_RESTART: begin
              if (handle_ok && alu_res_i.period_ok) begin
                ram_we_o            = 1'b1;
                ram_waddr_o         = hslot;
                ram_wdata_o.period  = cmd_i.elapse;
                ram_wdata_o.elapsed = '0;
                busy_d[hslot]       = 1'b1;
              end
              state_d = S_ACK;
            end
            default: begin
              state_d = S_ACK;
            end
          endcase
        end
      end

      // read slot idx while updating the slot whose read was issued before it
      S_WALK: begin
        if (!(ev && !out_free)) begin
          if (pv_q) begin
            if (op_q == CMD_TICK && proc_busy) begin
              ram_we_o            = 1'b1;
              ram_wdata_o.period  = ram_rdata_i.period;
              ram_wdata_o.elapsed = alu_res_i.elapsed_inc;
            end else if (op_q == CMD_POLL && proc_exp) begin
              ram_we_o            = 1'b1;
              ram_wdata_o.period  = ram_rdata_i.period;
              ram_wdata_o.elapsed = '0;
            end
            if (ev) begin
              out_valid_d = 1'b1;
              out_kind_d  = KIND_EXPIRY;
              out_id_d    = pid8[HandleW-1:0];
              out_last_d  = 1'b0;
            end
          end
          if (walk_done) begin
            pv_d    = 1'b0;
            state_d = S_ACK;
          end else begin
            ram_re_o = 1'b1;
            pidx_d   = islot;
            pv_d     = 1'b1;
            idx_d    = idx_q + CntW'(1);
          end
        end
      end

      // look for the lowest free slot, one slot per cycle
      S_ALLOC: begin
        if (walk_done) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_ALLOC;
            out_id_d    = '0;
            out_last_d  = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (busy_q[islot]) begin
          idx_d = idx_q + CntW'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_ALLOC;
          out_last_d  = 1'b1;
          out_id_d    = '0;
          if (alu_res_i.period_ok) begin
            ram_we_o            = 1'b1;
            ram_waddr_o         = islot;
            ram_wdata_o.period  = elapse_q;
            ram_wdata_o.elapsed = '0;
            busy_d[islot]       = 1'b1;
            act_d[islot]        = action_q;
            out_id_d            = aid8[HandleW-1:0];
          end
          state_d = S_IDLE;
        end
      end

      S_ACK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_ACK;
          out_id_d    = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      pv_q        <= 1'b0;
      busy_q      <= '0;
      act_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pv_q        <= pv_d;
      busy_q      <= busy_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    elapse_q   <= elapse_d;
    action_q   <= action_d;
    pidx_q     <= pidx_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire

/* design/timer_pool_engine.sv */
// Tick and poll: walk the period/count memory one slot per cycle, pausing while an
// expiry event waits on rsp_o, then acknowledge.
// Allocate: scan the busy flags one slot per cycle for the lowest free slot.
// Kill, restart and unknown commands are acknowledged directly. One command is in work at a time.
// Reset clears the busy and action flags and the handshake state asynchronously;
// the period/count memory is not cleared; a slot's word is only used once the slot is written.
`default_nettype none

module timer_pool_engine import tpe_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tpe_cmd_if.sink    cmd_i,
  tpe_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(POOL_DEPTH + 1);

  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  slot_word_t         ram_wdata;
  logic               ram_re;
  logic [IdxW-1:0]    ram_raddr;
  slot_word_t         ram_rdata;
  logic [PeriodW-1:0] alu_elapse;
  alu_res_t           alu_res;

  // sequencer, flags and response register
  tpe_seq #(
    .PoolDepth (POOL_DEPTH),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .rsp_o        (rsp_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .alu_elapse_o (alu_elapse),
    .alu_res_i    (alu_res)
  );

  // period and elapsed count store
  tpe_slot_ram #(
    .Depth (POOL_DEPTH),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared increment and compare unit
  tpe_slot_alu u_alu (
    .slot_i   (ram_rdata),
    .elapse_i (alu_elapse),
    .res_o    (alu_res)
  );

endmodule

`default_nettype wire

/* sim/timer_pool_checker.sv */
`timescale 1ns / 1ps

module timer_pool_checker import tpe_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tpe_cmd_if          cmd_mon,
  tpe_rsp_if          rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned responses_o,
  output int unsigned expiries_o
);

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [HandleW-1:0] timer_id;
    logic               last;
  } timer_rsp_t;

  // shadow copy of the timer pool
  logic               pool_busy   [POOL_DEPTH];
  logic [PeriodW-1:0] pool_period [POOL_DEPTH];
  logic [PeriodW-1:0] pool_count  [POOL_DEPTH];
  logic               pool_action [POOL_DEPTH];

  timer_rsp_t  expected_rsp_q[$];
  int unsigned mismatches;
  int unsigned responses_seen;
  int unsigned expiries_seen;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_rsp_q.size();
  assign responses_o  = responses_seen;
  assign expiries_o   = expiries_seen;

  function automatic timer_rsp_t make_rsp(logic [KindW-1:0] kind, logic [HandleW-1:0] id,
                                          logic last);
    timer_rsp_t r;
    r.kind     = kind;
    r.timer_id = id;
    r.last     = last;
    return r;
  endfunction

  function automatic logic handle_ok(logic [HandleW-1:0] hnd);
    return (hnd != '0) && (int'(hnd) <= int'(POOL_DEPTH));
  endfunction

  // update the shadow pool for one command and queue the responses it causes
  task automatic apply_command(input logic [CmdW-1:0] op, input logic [HandleW-1:0] hnd,
                               input logic [PeriodW-1:0] per, input logic act);
    logic               found;
    logic [HandleW-1:0] id;
    int                 slot;
    found = 1'b0;
    id    = '0;
    case (op)
      CMD_TICK: begin
        for (int i = 0; i < int'(POOL_DEPTH); i++) begin
          if (pool_busy[i]) begin
            if (pool_count[i] >= PERIOD_MAX) pool_count[i] = COUNT_SAT;
            else pool_count[i] = pool_count[i] + 1'b1;
          end
        end
        expected_rsp_q.push_back(make_rsp(KIND_ACK, '0, 1'b1));
      end
      CMD_ALLOC: begin
        // lowest free slot wins; an oversized period leaves the pool untouched
        for (int i = 0; i < int'(POOL_DEPTH); i++) begin
          if (!found && !pool_busy[i]) begin
            found = 1'b1;
            if (per <= PERIOD_MAX) begin
              pool_busy[i]   = 1'b1;
              pool_period[i] = per;
              pool_action[i] = act;
              id             = HandleW'(i + 1);
            end
          end
        end
        expected_rsp_q.push_back(make_rsp(KIND_ALLOC, id, 1'b1));
      end
      CMD_KILL: begin
        if (handle_ok(hnd)) begin
          slot              = int'(hnd) - 1;
          pool_busy[slot]   = 1'b0;
          pool_period[slot] = '0;
          pool_count[slot]  = '0;
          pool_action[slot] = 1'b0;
        end
        expected_rsp_q.push_back(make_rsp(KIND_ACK, '0, 1'b1));
      end
      CMD_RESTART: begin
        // action flag is kept, so a restarted free slot expires silently
        if (handle_ok(hnd) && per <= PERIOD_MAX) begin
          slot              = int'(hnd) - 1;
          pool_period[slot] = per;
          pool_count[slot]  = '0;
          pool_busy[slot]   = 1'b1;
        end
        expected_rsp_q.push_back(make_rsp(KIND_ACK, '0, 1'b1));
      end
      CMD_POLL: begin
        for (int i = 0; i < int'(POOL_DEPTH); i++) begin
          if (pool_busy[i] && pool_count[i] >= pool_period[i]) begin
            if (pool_action[i])
              expected_rsp_q.push_back(make_rsp(KIND_EXPIRY, HandleW'(i + 1), 1'b0));
            pool_count[i] = '0;
          end
        end
        expected_rsp_q.push_back(make_rsp(KIND_ACK, '0, 1'b1));
      end
      default: begin
        expected_rsp_q.push_back(make_rsp(KIND_ACK, '0, 1'b1));
      end
    endcase
  endtask

  // compare one response transfer with the oldest expectation
  task automatic check_response(input timer_rsp_t got);
    timer_rsp_t want;
    if (expected_rsp_q.size() == 0) begin
      $error("unexpected response: kind %0d timer_id %0d last %0d",
             got.kind, got.timer_id, got.last);
      mismatches++;
    end else begin
      want = expected_rsp_q.pop_front();
      if (got.kind != want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.timer_id != want.timer_id) begin
        $error("timer_id: expected %0d, got %0d", want.timer_id, got.timer_id);
        mismatches++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    end
    responses_seen++;
    if (got.kind == KIND_EXPIRY) expiries_seen++;
  endtask

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(POOL_DEPTH); i++) begin
        pool_busy[i]   = 1'b0;
        pool_period[i] = '0;
        pool_count[i]  = '0;
        pool_action[i] = 1'b0;
      end
      expected_rsp_q.delete();
      mismatches     = 0;
      responses_seen = 0;
      expiries_seen  = 0;
    end else begin
      if (cmd_mon.valid && cmd_mon.ready)
        apply_command(cmd_mon.command, cmd_mon.handle, cmd_mon.elapse, cmd_mon.has_action);
      if (rsp_mon.valid && rsp_mon.ready)
        check_response(make_rsp(rsp_mon.kind, rsp_mon.timer_id, rsp_mon.last));
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb import tpe_pkg::*; ();

  localparam int unsigned POOL_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * POOL_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 250000;

  // command codes the block does not define
  localparam logic [CmdW-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CmdW-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam logic [PeriodW-1:0] PERIOD_ALL_ONES = '1;
  localparam logic [HandleW-1:0] HANDLE_ALL_ONES = '1;

  logic clk;
  logic rst_n;

  tpe_cmd_if cmd_bus ();
  tpe_rsp_if rsp_bus ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned responses;
  int unsigned expiries;

  int unsigned cycle_cnt;
  int unsigned cmd_count [8];
  logic        gaps_on;
  logic        hold_req;

  timer_pool_engine #(.POOL_DEPTH(POOL_DEPTH)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  timer_pool_checker #(.POOL_DEPTH(POOL_DEPTH)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_mon      (cmd_bus),
    .rsp_mon      (rsp_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .responses_o  (responses),
    .expiries_o   (expiries)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run length guard
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still expected", cycle_cnt, pending);
      $display("** timer_pool_engine: FAILED **");
      $finish;
    end
  end

  // response side: random stalls, one quiet window and one long hold-off
  initial begin : rsp_side
    int unsigned rx_cycle;
    int unsigned hold_left;
    logic        hold_done;
    rx_cycle  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_left != 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        rsp_bus.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else if (rx_cycle >= 1500 && rx_cycle < 3000) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // offer one command and wait for its transfer
  task automatic send_cmd(input logic [CmdW-1:0] op, input logic [HandleW-1:0] hnd,
                          input logic [PeriodW-1:0] per, input logic act);
    while (gaps_on && $urandom_range(0, 99) < 6) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= op;
    cmd_bus.handle     <= hnd;
    cmd_bus.elapse     <= per;
    cmd_bus.has_action <= act;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    cmd_count[op]++;
    @(negedge clk);
  endtask

  // stop offering until every expected response has come back
  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly well-formed traffic on a small pool of short periods, some noise
  task automatic send_random();
    int unsigned        r;
    logic [CmdW-1:0]    op;
    logic [HandleW-1:0] hnd;
    logic [PeriodW-1:0] per;
    logic               act;
    r   = $urandom_range(0, 99);
    hnd = HandleW'($urandom_range(0, 31));
    per = PeriodW'($urandom());
    act = 1'($urandom_range(0, 1));
    if (r < 28) begin
      op = CMD_TICK;
    end else if (r < 48) begin
      op = CMD_POLL;
    end else if (r < 68) begin
      op  = CMD_ALLOC;
      per = PeriodW'($urandom_range(0, 6));
    end else if (r < 80) begin
      op  = CMD_KILL;
      hnd = HandleW'($urandom_range(1, POOL_DEPTH));
    end else if (r < 92) begin
      op  = CMD_RESTART;
      hnd = HandleW'($urandom_range(1, POOL_DEPTH));
      per = PeriodW'($urandom_range(0, 6));
    end else begin
      case ($urandom_range(0, 3))
        0: op = CMD_SPARE_FIRST + CmdW'($urandom_range(0, 2));
        1: begin
          op  = $urandom_range(0, 1) ? CMD_KILL : CMD_RESTART;
          hnd = $urandom_range(0, 3) == 0 ? '0 : HandleW'($urandom_range(POOL_DEPTH + 1, 31));
          per = PeriodW'($urandom_range(0, 6));
        end
        2: begin
          op  = $urandom_range(0, 1) ? CMD_ALLOC : CMD_RESTART;
          hnd = HandleW'($urandom_range(1, POOL_DEPTH));
          per = PeriodW'($urandom_range(int'(PERIOD_MAX) + 1, 65535));
        end
        default: op = CmdW'($urandom_range(int'(CMD_TICK), int'(CMD_POLL)));
      endcase
    end
    send_cmd(op, hnd, per, act);
  endtask

  // stimulus and verdict
  initial begin
    cmd_bus.valid      = 1'b0;
    cmd_bus.command    = CMD_TICK;
    cmd_bus.handle     = '0;
    cmd_bus.elapse     = '0;
    cmd_bus.has_action = 1'b0;
    gaps_on            = 1'b1;
    hold_req           = 1'b0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty pool, period limits, bad handles, silent expiry, spare codes
    send_cmd(CMD_TICK,    '0,              '0,              1'b0);
    send_cmd(CMD_POLL,    '0,              '0,              1'b0);
    send_cmd(CMD_ALLOC,   '0,              '0,              1'b1);
    send_cmd(CMD_ALLOC,   '0,              PERIOD_MAX,      1'b0);
    send_cmd(CMD_ALLOC,   '0,              PERIOD_MAX + 16'd1, 1'b1);
    send_cmd(CMD_ALLOC,   HANDLE_ALL_ONES, PERIOD_ALL_ONES, 1'b1);
    send_cmd(CMD_ALLOC,   '0,              16'd2,           1'b1);
    send_cmd(CMD_TICK,    HANDLE_ALL_ONES, PERIOD_ALL_ONES, 1'b1);
    send_cmd(CMD_TICK,    '0,              '0,              1'b0);
    send_cmd(CMD_POLL,    '0,              '0,              1'b0);
    send_cmd(CMD_RESTART, '0,              16'd1,           1'b0);
    send_cmd(CMD_RESTART, HandleW'(POOL_DEPTH + 1), 16'd1,  1'b0);
    send_cmd(CMD_RESTART, HANDLE_ALL_ONES, '0,              1'b1);
    send_cmd(CMD_RESTART, 5'd2,            PERIOD_MAX + 16'd1, 1'b0);
    send_cmd(CMD_RESTART, 5'd9,            '0,              1'b1);
    send_cmd(CMD_KILL,    '0,              '0,              1'b0);
    send_cmd(CMD_KILL,    HANDLE_ALL_ONES, '0,              1'b0);
    send_cmd(CMD_KILL,    HandleW'(POOL_DEPTH), '0,         1'b0);
    send_cmd(CMD_SPARE_FIRST,         5'd1, 16'd3,          1'b1);
    send_cmd(CMD_SPARE_FIRST + 3'd1,  5'd2, 16'd4,          1'b0);
    send_cmd(CMD_SPARE_LAST,          5'd3, 16'd5,          1'b1);
    send_cmd(CMD_POLL,    '0,              '0,              1'b0);
    send_cmd(CMD_KILL,    5'd1,            '0,              1'b0);
    send_cmd(CMD_RESTART, 5'd1,            16'd0,           1'b1);
    send_cmd(CMD_POLL,    '0,              '0,              1'b0);

    // random traffic with a gap-free stretch, a receiver hold-off and a full drain
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 100 && n < 180);
      if (n == 150) hold_req = 1'b1;
      if (n == 250) wait_drained();
      send_random();
    end

    cmd_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("commands: %0d tick, %0d allocate, %0d kill, %0d restart, %0d poll, %0d spare",
             cmd_count[CMD_TICK], cmd_count[CMD_ALLOC], cmd_count[CMD_KILL],
             cmd_count[CMD_RESTART], cmd_count[CMD_POLL],
             cmd_count[CMD_SPARE_FIRST] + cmd_count[CMD_SPARE_FIRST + 3'd1] +
             cmd_count[CMD_SPARE_LAST]);
    $display("responses checked: %0d, expiry events among them: %0d, cycles: %0d",
             responses, expiries, cycle_cnt);
    if (fail_count == 0 && pending == 0) begin
      $display("** timer_pool_engine: PASSED **");
    end else begin
      $display("** timer_pool_engine: FAILED **");
    end
    $finish;
  end

endmodule
